// ===== rtl/fbe_pkg.sv =====
// ----------------------------------------------------------------------------
// fbe_pkg
// Shared types, constants and the header byte table of the BMP24 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fbe_pkg;

  localparam int unsigned FBE_MAX_DIMENSION = 4096;
  localparam int unsigned FBE_QUEUE_DEPTH   = 2;

  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MODE   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 13'd320;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 13'd240;
  localparam logic                  RST_PIXEL_MODE   = 1'b1;

  localparam logic MODE_RGB332 = 1'b0;
  localparam logic MODE_RGB565 = 1'b1;

  localparam logic [5:0]  HDR_LAST        = 6'd53;
  localparam logic [31:0] HDR_BYTES       = 32'd54;
  localparam logic [7:0]  INFO_BYTES      = 8'd40;
  localparam logic [7:0]  BITS_PER_PIXEL  = 8'd24;
  localparam logic [31:0] PELS_PER_METRE  = 32'd2835;
  localparam logic [7:0]  MAGIC_B         = 8'h42;
  localparam logic [7:0]  MAGIC_M         = 8'h4D;

  localparam logic [5:0] OFS_FSIZE  = 6'd2;
  localparam logic [5:0] OFS_OFFSET = 6'd10;
  localparam logic [5:0] OFS_INFO   = 6'd14;
  localparam logic [5:0] OFS_WIDTH  = 6'd18;
  localparam logic [5:0] OFS_HEIGHT = 6'd22;
  localparam logic [5:0] OFS_PLANES = 6'd26;
  localparam logic [5:0] OFS_BPP    = 6'd28;
  localparam logic [5:0] OFS_IMAGE  = 6'd34;
  localparam logic [5:0] OFS_XRES   = 6'd38;
  localparam logic [5:0] OFS_YRES   = 6'd42;

  typedef struct packed {
    logic       hdr;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] pad;
    logic       done;
  } fbe_desc_t;

  function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] sel);
    logic [7:0] res;
    res = v[8*sel +: 8];
    return res;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [5:0]  idx,
                                          input logic [31:0] w,
                                          input logic [31:0] h,
                                          input logic [31:0] img,
                                          input logic [31:0] fsize);
    logic [7:0] res;
    res = 8'h00;
    unique case (idx) inside
      6'd0:                            res = MAGIC_B;
      6'd1:                            res = MAGIC_M;
      [OFS_FSIZE:OFS_FSIZE+6'd3]:      res = le_byte(fsize, 2'(idx - OFS_FSIZE));
      OFS_OFFSET:                      res = HDR_BYTES[7:0];
      OFS_INFO:                        res = INFO_BYTES;
      [OFS_WIDTH:OFS_WIDTH+6'd3]:      res = le_byte(w, 2'(idx - OFS_WIDTH));
      [OFS_HEIGHT:OFS_HEIGHT+6'd3]:    res = le_byte(h, 2'(idx - OFS_HEIGHT));
      OFS_PLANES:                      res = 8'd1;
      OFS_BPP:                         res = BITS_PER_PIXEL;
      [OFS_IMAGE:OFS_IMAGE+6'd3]:      res = le_byte(img, 2'(idx - OFS_IMAGE));
      [OFS_XRES:OFS_XRES+6'd3]:        res = le_byte(PELS_PER_METRE, 2'(idx - OFS_XRES));
      [OFS_YRES:OFS_YRES+6'd3]:        res = le_byte(PELS_PER_METRE, 2'(idx - OFS_YRES));
      default:                         res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/framebuffer_to_bmp24_encoder.sv =====
// ----------------------------------------------------------------------------
// framebuffer_to_bmp24_encoder
// Streams framebuffer pixels out as the bytes of a 24-bit BMP file.
// ----------------------------------------------------------------------------
// Pixels arrive in BMP order (bottom row first) as RGB565 or RGB332 and leave
// as a byte stream: the 54-byte header ahead of the first pixel of each frame,
// then B, G, R per pixel and zero padding to a 4-byte boundary after each row.
// A two-entry queue lets the pixel side keep accepting while bytes drain, until
// it is full; the first byte of an item passes through the queue and the
// registered byte output of the serializer.
// run_last_o marks the last byte of each pixel, after any row padding, and
// image_done_o the last byte of the file.
// Dimension registers of 0 count as 1, values above MAX_DIMENSION as
// MAX_DIMENSION. Write configuration only while no bytes are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_to_bmp24_encoder
  import fbe_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = FBE_MAX_DIMENSION,
  parameter int unsigned QUEUE_DEPTH   = FBE_QUEUE_DEPTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [15:0]            pixel_value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [7:0]                  file_byte_o,
  output logic                        run_last_o,
  output logic                        image_done_o
);

  localparam int unsigned DimW = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CmpW = (DimW > CFG_DATA_W) ? DimW : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  mode_q;
  logic [DimW-1:0]       width_eff, height_eff;

  fbe_desc_t push_data, pop_data;
  logic      push, full, pop, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      mode_q   <= RST_PIXEL_MODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_PIXEL_MODE:   mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [DimW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [CmpW-1:0] ext;
    logic [DimW-1:0] res;
    ext = CmpW'(v);
    if (ext == '0) begin
      res = DimW'(1);
    end else if (ext > CmpW'(MAX_DIMENSION)) begin
      res = DimW'(MAX_DIMENSION);
    end else begin
      res = DimW'(ext);
    end
    return res;
  endfunction

  assign width_eff  = clamp_dim(width_q);
  assign height_eff = clamp_dim(height_q);

  fbe_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_value_i(pixel_value_i),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .mode_i       (mode_q),
    .q_push_o     (push),
    .q_data_o     (push_data),
    .q_full_i     (full)
  );

  fbe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .valid_o    (q_valid)
  );

  fbe_back #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .q_data_i    (pop_data),
    .q_valid_i   (q_valid),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .file_byte_o (file_byte_o),
    .run_last_o  (run_last_o),
    .image_done_o(image_done_o)
  );

endmodule

`default_nettype wire

// ===== rtl/fbe_front.sv =====
// ----------------------------------------------------------------------------
// fbe_front
// Accepts pixels, expands them to 8-bit channels and tracks the frame position.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_front
  import fbe_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = FBE_MAX_DIMENSION,
  localparam int unsigned DimW = $clog2(MAX_DIMENSION + 1),
  localparam int unsigned CntW = $clog2(MAX_DIMENSION)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [15:0]     pixel_value_i,
  input  wire logic [DimW-1:0] width_i,
  input  wire logic [DimW-1:0] height_i,
  input  wire logic            mode_i,
  output logic                 q_push_o,
  output fbe_desc_t            q_data_o,
  input  wire logic            q_full_i
);

  logic            hdr_pending_q, hdr_pending_d;
  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  logic [DimW-1:0] col_inc, row_inc;
  logic            row_end, frame_end;
  logic [7:0]      red, green, blue;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    if (mode_i == MODE_RGB565) begin
      red   = {pixel_value_i[15:11], pixel_value_i[15:13]};
      green = {pixel_value_i[10:5], pixel_value_i[10:9]};
      blue  = {pixel_value_i[4:0], pixel_value_i[4:2]};
    end else begin
      red   = {pixel_value_i[7:5], pixel_value_i[7:5], pixel_value_i[7:6]};
      green = {pixel_value_i[4:2], pixel_value_i[4:2], pixel_value_i[4:3]};
      blue  = {4{pixel_value_i[1:0]}};
    end
  end

  always_comb begin
    col_inc   = DimW'(col_q) + DimW'(1);
    row_inc   = DimW'(row_q) + DimW'(1);
    row_end   = col_inc >= width_i;
    frame_end = row_end && (row_inc >= height_i);

    col_d         = row_end ? '0 : CntW'(col_inc);
    row_d         = row_end ? (frame_end ? '0 : CntW'(row_inc)) : row_q;
    hdr_pending_d = frame_end;

    q_data_o.hdr   = hdr_pending_q;
    q_data_o.blue  = blue;
    q_data_o.green = green;
    q_data_o.red   = red;
    // row padding to a 4-byte boundary equals width mod 4
    q_data_o.pad   = row_end ? width_i[1:0] : 2'd0;
    q_data_o.done  = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pending_q <= 1'b1;
      col_q         <= '0;
      row_q         <= '0;
    end else if (q_push_o) begin
      hdr_pending_q <= hdr_pending_d;
      col_q         <= col_d;
      row_q         <= row_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbe_queue.sv =====
// ----------------------------------------------------------------------------
// fbe_queue
// Short descriptor queue between the pixel front end and the byte back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_queue
  import fbe_pkg::*;
#(
  parameter int unsigned DEPTH = FBE_QUEUE_DEPTH,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire fbe_desc_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output fbe_desc_t      pop_data_o,
  output logic           valid_o
);

  fbe_desc_t       entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = cnt_q == CntW'(DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] res;
    res = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
    return res;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbe_back.sv =====
// ----------------------------------------------------------------------------
// fbe_back
// Serializes header, pixel and padding bytes into the registered byte output.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_back
  import fbe_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = FBE_MAX_DIMENSION,
  localparam int unsigned DimW = $clog2(MAX_DIMENSION + 1),
  localparam int unsigned RowW = DimW + 2,
  localparam int unsigned ProdW = RowW + DimW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [DimW-1:0] width_i,
  input  wire logic [DimW-1:0] height_i,
  input  wire fbe_desc_t       q_data_i,
  input  wire logic            q_valid_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           file_byte_o,
  output logic                 run_last_o,
  output logic                 image_done_o
);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_PIX = 2'd1;
  localparam logic [1:0] PH_PAD = 2'd2;

  logic [RowW-1:0]  row_bytes;
  logic [ProdW-1:0] prod;
  logic [31:0]      img_q, fsize_q;

  fbe_desc_t  cur_q, src;
  logic       busy_q;
  logic [1:0] ph_q, ph, ph_nxt;
  logic [5:0] idx_q, idx, idx_nxt;
  logic       active, adv, item_end;
  logic [7:0] byte_val;

  logic       ov_q;
  logic [7:0] obyte_q;
  logic       olast_q, odone_q;

  assign row_bytes = RowW'(width_i) * RowW'(3) + RowW'(width_i[1:0]);
  assign prod      = ProdW'(row_bytes) * ProdW'(height_i);

  always_ff @(posedge clk_i) begin
    img_q   <= 32'(prod);
    fsize_q <= img_q + HDR_BYTES;
  end

  always_comb begin
    active   = busy_q || q_valid_i;
    adv      = !ov_q || !out_stall_i;
    src      = busy_q ? cur_q : q_data_i;
    ph       = busy_q ? ph_q : (q_data_i.hdr ? PH_HDR : PH_PIX);
    idx      = busy_q ? idx_q : 6'd0;
    q_pop_o  = adv && !busy_q && q_valid_i;

    byte_val = 8'h00;
    ph_nxt   = ph;
    idx_nxt  = idx + 6'd1;
    item_end = 1'b0;
    unique case (ph)
      PH_HDR: begin
        byte_val = hdr_byte(idx, 32'(width_i), 32'(height_i), img_q, fsize_q);
        if (idx == HDR_LAST) begin
          ph_nxt  = PH_PIX;
          idx_nxt = 6'd0;
        end
      end
      PH_PIX: begin
        case (idx[1:0])
          2'd0:    byte_val = src.blue;
          2'd1:    byte_val = src.green;
          default: byte_val = src.red;
        endcase
        if (idx[1:0] == 2'd2) begin
          if (src.pad != 2'd0) begin
            ph_nxt  = PH_PAD;
            idx_nxt = 6'd0;
          end else begin
            item_end = 1'b1;
          end
        end
      end
      PH_PAD: begin
        byte_val = 8'h00;
        item_end = idx[1:0] == (src.pad - 2'd1);
      end
      default: begin
        item_end = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv && active) begin
      obyte_q <= byte_val;
      olast_q <= item_end;
      odone_q <= item_end && src.done;
      ph_q    <= ph_nxt;
      idx_q   <= idx_nxt;
      if (!busy_q) begin
        cur_q <= q_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      busy_q <= 1'b0;
    end else if (adv) begin
      ov_q <= active;
      if (active) begin
        busy_q <= !item_end;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign file_byte_o  = obyte_q;
  assign run_last_o   = olast_q;
  assign image_done_o = odone_q;

endmodule

`default_nettype wire

// ===== rtl/fbe_checker.sv =====
// ----------------------------------------------------------------------------
// fbe_checker
// Port-level checks on the BMP24 encoder byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_checker
  import fbe_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic       in_valid_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] file_byte_o,
  input wire logic       run_last_o,
  input wire logic       image_done_o
);

  logic expect_hdr_q;
  logic out_take;

  assign out_take = out_valid_o && !out_stall_i;

  // next byte taken starts a new file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
    end else if (out_take) begin
      expect_hdr_q <= image_done_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(file_byte_o) && $stable(run_last_o) && $stable(image_done_o))
    else $error("stalled output item changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o |-> run_last_o)
    else $error("end of file not on last byte of a pixel");

  a_file_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && expect_hdr_q |-> file_byte_o == MAGIC_B)
    else $error("file does not start with header magic");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && !in_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind framebuffer_to_bmp24_encoder fbe_checker u_fbe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .in_valid_i   (in_valid_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .file_byte_o  (file_byte_o),
  .run_last_o   (run_last_o),
  .image_done_o (image_done_o)
);

`default_nettype wire
